// File: rtl/waveshaper_table_interpolator_macros.svh
// Assertion macros shared by the waveshaper table interpolator RTL.
// Depends on nothing; files that check their logic include it.
`ifndef WAVESHAPER_TABLE_INTERPOLATOR_MACROS_SVH
`define WAVESHAPER_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define WTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("waveshaper check failed");

// Next-cycle implication, checked only outside reset.
`define WTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("waveshaper check failed");

`endif

// File: rtl/wti_pkg.sv
// Shared types, constants and geometry functions of the waveshaper table interpolator.
// Depends on nothing; used by wti_interp, the top level and the testbench.
`timescale 1ns / 1ps

package wti_pkg;

	localparam int DATA_W            = 16;
	localparam int INDEX_W           = 9;
	localparam int SAMPLE_W          = 16;
	localparam int TABLE_ENTRIES_DEF = 257;
	localparam int SAMPLE_BITS_DEF   = 16;

	typedef enum logic {
		CMD_MAP   = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// Number of index bits: floor(log2(entries - 1)).
	function automatic int idx_bits(input int entries);
		return $clog2(entries) - 1;
	endfunction

	// Number of fraction bits below the segment index, never negative.
	function automatic int frac_bits(input int entries, input int sbits);
		int ib;
		ib = idx_bits(entries);
		return (sbits > ib) ? (sbits - ib) : 0;
	endfunction

	// Width of the fraction signal; at least one bit even with no fraction.
	function automatic int frac_w(input int entries, input int sbits);
		int fb;
		fb = frac_bits(entries, sbits);
		return (fb > 0) ? fb : 1;
	endfunction

endpackage

// File: rtl/wti_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module wti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/wti_interp.sv
// Interpolation pipeline: difference, multiply by fraction, scale and add.
// Depends on wti_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "waveshaper_table_interpolator_macros.svh"

module wti_interp
	import wti_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          map_load,
	input  logic [frac_w(TABLE_ENTRIES, SAMPLE_BITS)-1:0] frac,
	input  logic signed [DATA_W-1:0]                      cur,
	input  logic signed [DATA_W-1:0]                      nxt,
	input  logic                                          result_stall,
	output logic                                          ready,
	output logic                                          result_valid,
	output logic signed [DATA_W-1:0]                      sample_out
);

	localparam int FB = frac_bits(TABLE_ENTRIES, SAMPLE_BITS);
	localparam int FW = frac_w(TABLE_ENTRIES, SAMPLE_BITS);
	localparam int PW = DATA_W + FW + 2;
	localparam logic signed [PW-1:0] BIAS = PW'((64'd1 << FB) - 64'd1);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;

	logic [FW-1:0]              frac_s1, frac_s2;
	logic signed [DATA_W:0]     diff_s2;
	logic signed [DATA_W-1:0]   cur_s2, cur_s3;
	logic signed [PW-1:0]       prod_s3;
	logic signed [DATA_W-1:0]   res_s4;

	logic signed [DATA_W:0]     diff_c;
	logic signed [FW:0]         frac_ext;
	logic signed [PW-1:0]       prod_c;
	logic signed [PW-1:0]       term_c;
	logic signed [PW-1:0]       sum_c;

	// A stage may load when it is empty or its content moves on.
	assign ready4 = !valid_s4 || !result_stall;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;
	assign ready  = ready1;

	assign diff_c   = (DATA_W + 1)'(nxt) - (DATA_W + 1)'(cur);
	assign frac_ext = $signed({1'b0, frac_s2});
	assign prod_c   = diff_s2 * frac_ext;

	// Division by 2^FB that truncates toward zero: bias negative products first.
	assign term_c = (prod_s3 + (prod_s3[PW-1] ? BIAS : PW'(0))) >>> FB;
	assign sum_c  = PW'(cur_s3) + term_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= map_load;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (map_load && ready1) begin
			frac_s1 <= frac;
		end
		if (valid_s1 && ready2) begin
			frac_s2 <= frac_s1;
			diff_s2 <= diff_c;
			cur_s2  <= cur;
		end
		if (valid_s2 && ready3) begin
			prod_s3 <= prod_c;
			cur_s3  <= cur_s2;
		end
		if (valid_s3 && ready4) begin
			res_s4 <= sum_c[DATA_W-1:0];
		end
	end

	assign result_valid = valid_s4;
	assign sample_out   = res_s4;

	`WTI_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !ready1, valid_s1 && valid_s2 && valid_s3 && valid_s4)
	`WTI_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !ready2, valid_s1 && $stable(frac_s1))
	`WTI_ASSERT_NEXT(a_s3_moves_on, clk, arst_n, valid_s3 && ready4, valid_s4)

endmodule

// File: rtl/waveshaper_table_interpolator.sv
// Top level of the waveshaper table interpolator: command decode, table RAMs, pipeline.
// Depends on wti_pkg, wti_ram and wti_interp.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall      command, sample_in, entry_index,
//                                                     entry_value
//   result    out        result_valid / result_stall  sample_out
//
// One item enters per cycle while item_stall is low. A map transaction passes the table
// reads, difference, multiply, then scale and add, one register each, before result_valid
// rises.
// The table sits in two copies of one RAM so both neighbor entries are read in the same cycle.
// Reset clears only the pipeline valid bits; table entries are undefined until written.
// A stalled result holds the output register; earlier stages keep filling until full.
`timescale 1ns / 1ps

module waveshaper_table_interpolator
	import wti_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       command,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [INDEX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0]   entry_value,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [DATA_W-1:0]   sample_out
);

	localparam int AW   = $clog2(TABLE_ENTRIES);
	localparam int FB   = frac_bits(TABLE_ENTRIES, SAMPLE_BITS);
	localparam int FW   = frac_w(TABLE_ENTRIES, SAMPLE_BITS);
	localparam int SEGW = (SAMPLE_BITS > AW) ? SAMPLE_BITS : AW;
	localparam logic [SEGW-1:0] SEG_MAX = SEGW'(TABLE_ENTRIES - 2);

	logic                   ready;
	logic                   accept;
	logic                   map_load;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [SAMPLE_BITS-1:0] samp;
	logic [SAMPLE_BITS-1:0] offset;
	logic [SEGW-1:0]        seg;
	logic [AW-1:0]          addr_cur;
	logic [AW-1:0]          addr_nxt;
	logic [FW-1:0]          frac;
	logic [DATA_W-1:0]      cur_raw;
	logic [DATA_W-1:0]      nxt_raw;

	assign item_stall = !ready;
	assign accept     = item_valid && ready;
	assign map_load   = accept && (cmd_t'(command) == CMD_MAP);
	assign wr_en      = accept && (cmd_t'(command) == CMD_WRITE)
	                    && (32'(entry_index) < 32'(TABLE_ENTRIES));
	assign wr_addr    = AW'(entry_index);

	// Adding half scale to a two's complement sample flips its top bit.
	assign samp   = SAMPLE_BITS'($unsigned(sample_in));
	assign offset = {~samp[SAMPLE_BITS-1], samp[SAMPLE_BITS-2:0]};
	assign seg    = SEGW'(offset) >> FB;

	// Clamp the index so that it never passes the last segment.
	assign addr_cur = (seg > SEG_MAX) ? AW'(SEG_MAX) : AW'(seg);
	assign addr_nxt = addr_cur + AW'(1);

	generate
		if (FB > 0) begin : g_frac
			assign frac = offset[FW-1:0];
		end else begin : g_no_frac
			assign frac = '0;
		end
	endgenerate

	wti_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram_cur (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(entry_value),
		.re   (map_load),
		.raddr(addr_cur),
		.rdata(cur_raw)
	);

	wti_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram_nxt (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(entry_value),
		.re   (map_load),
		.raddr(addr_nxt),
		.rdata(nxt_raw)
	);

	wti_interp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.map_load    (map_load),
		.frac        (frac),
		.cur         ($signed(cur_raw)),
		.nxt         ($signed(nxt_raw)),
		.result_stall(result_stall),
		.ready       (ready),
		.result_valid(result_valid),
		.sample_out  (sample_out)
	);

endmodule

// File: tb/tb_waveshaper_table_interpolator.sv
// Self-checking testbench for the waveshaper table interpolator: table writes and mapped samples.
// Depends on wti_pkg and waveshaper_table_interpolator; predicts every mapped sample locally.
`timescale 1ns / 1ps

module tb_waveshaper_table_interpolator;
	import wti_pkg::*;

	localparam int SEG_BITS  = $clog2(TABLE_ENTRIES_DEF - 1);
	localparam int FRAC_BITS = SAMPLE_BITS_DEF - SEG_BITS;
	localparam int RANDOM_ITEMS = 1400;

	class shaper_scoreboard;
		logic signed [DATA_W-1:0] level_table [TABLE_ENTRIES_DEF];
		logic signed [DATA_W-1:0] expected_levels [$];
		int errors;

		function new();
			errors = 0;
			foreach (level_table[i]) level_table[i] = '0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		// Offset the sample to unsigned, split it into segment and fraction, and interpolate.
		// Integer division truncates toward zero, as the block does.
		function logic signed [DATA_W-1:0] mapped_level(logic signed [SAMPLE_W-1:0] s);
			logic [SAMPLE_W-1:0] offset;
			int seg;
			int frac;
			int cur;
			int nxt;
			int term;
			offset = {~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
			seg = int'(offset >> FRAC_BITS);
			frac = int'(offset) & ((1 << FRAC_BITS) - 1);
			if (seg > TABLE_ENTRIES_DEF - 2)
				seg = TABLE_ENTRIES_DEF - 2;
			cur = level_table[seg];
			nxt = level_table[seg + 1];
			term = ((nxt - cur) * frac) / (1 << FRAC_BITS);
			return DATA_W'(cur + term);
		endfunction

		function void note_item(cmd_t cmd, logic signed [SAMPLE_W-1:0] s,
				logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] val);
			if (cmd == CMD_WRITE) begin
				if (idx < TABLE_ENTRIES_DEF)
					level_table[idx] = val;
			end else begin
				expected_levels.push_back(mapped_level(s));
			end
		endfunction

		task check_result(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (expected_levels.size() == 0) begin
				report($sformatf("unexpected sample_out %0d", got));
			end else begin
				want = expected_levels.pop_front();
				if (got !== want)
					report($sformatf("sample_out %0d, expected %0d", got, want));
			end
		endtask

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       item_valid;
	logic                       item_stall;
	logic                       command;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [INDEX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0]   entry_value;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [DATA_W-1:0]   sample_out;

	shaper_scoreboard sb = new();
	bit sender_calm;
	bit receiver_calm;
	bit hold_request;

	waveshaper_table_interpolator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.sample_in    (sample_in),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_item(cmd_t cmd, logic signed [SAMPLE_W-1:0] s,
			logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] val);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		sample_in   <= s;
		entry_index <= idx;
		entry_value <= val;
		forever begin
			@(posedge clk);
			if (!item_stall)
				break;
		end
		sb.note_item(cmd, s, idx, val);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_level();
		unique case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Result side: stall for a drawn number of cycles, then take one transaction and check it.
	initial begin
		int hold;
		result_stall = 1'b0;
		forever begin
			if (hold_request) begin
				hold = 200;
				hold_request = 1'b0;
			end else begin
				hold = receiver_calm ? 0 : $urandom_range(0, 4);
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			forever begin
				@(posedge clk);
				if (result_valid)
					break;
			end
			sb.check_result(sample_out);
		end
	end

	initial begin
		#(5_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int counted;
		int calm_until;
		logic [INDEX_W-1:0] idx;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		command       = CMD_MAP;
		sample_in     = '0;
		entry_index   = '0;
		entry_value   = '0;
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		hold_request  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme levels at both table ends, a large positive step around the midpoint,
		// out-of-range writes, and garbage in the unused fields of every transaction.
		send_item(CMD_WRITE, 16'sh7fff, 9'd0,   16'sh8000);
		send_item(CMD_WRITE, 16'sh8000, 9'd1,   16'sh7fff);
		send_item(CMD_WRITE, 16'sh5555, 9'd255, 16'sh7fff);
		send_item(CMD_WRITE, 16'shaaaa, 9'd256, 16'sh8000);
		send_item(CMD_WRITE, 16'sh0000, 9'd127, 16'sh8000);
		send_item(CMD_WRITE, 16'shffff, 9'd128, 16'sd100);
		send_item(CMD_WRITE, 16'sh1234, 9'd129, -16'sd101);
		send_item(CMD_WRITE, 16'sh0000, 9'd257, 16'sh0000);
		send_item(CMD_WRITE, 16'sh0000, 9'd511, 16'sh1234);
		send_item(CMD_MAP, 16'sh8000,  9'h1ff, 16'sh8000);
		send_item(CMD_MAP, -16'sd32513, 9'h000, 16'sh7fff);
		send_item(CMD_MAP, -16'sd32640, 9'h155, 16'sh5555);
		send_item(CMD_MAP, 16'sh7fff,  9'h0aa, 16'shaaaa);
		send_item(CMD_MAP, 16'sd32512, 9'h100, 16'sh0000);
		send_item(CMD_MAP, 16'sd0,     9'h0ff, 16'shffff);
		send_item(CMD_MAP, -16'sd1,    9'h001, 16'sh0001);
		send_item(CMD_MAP, 16'sd128,   9'h1ff, 16'sh0000);
		send_item(CMD_MAP, 16'sd129,   9'h000, 16'sh0000);
		// A write followed at once by a read of the same entry.
		send_item(CMD_WRITE, 16'sh0f0f, 9'd1, 16'sh8000);
		send_item(CMD_MAP, -16'sd32513, 9'h101, 16'sh4321);

		// Fill the whole table so that every segment can be read from here on.
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
			send_item(CMD_WRITE, SAMPLE_W'($urandom), INDEX_W'(i), pick_level());

		counted = 0;
		calm_until = -1;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 128 == 0) begin
				sender_calm   = ($urandom_range(0, 3) == 0);
				receiver_calm = ($urandom_range(0, 3) == 0);
			end
			// Hold the result side off for a long stretch while items keep coming.
			if (counted == 600) begin
				hold_request = 1'b1;
				calm_until = 900;
			end
			if (counted < calm_until)
				sender_calm = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(257, 511))
					: INDEX_W'($urandom_range(0, 256));
				send_item(CMD_WRITE, SAMPLE_W'($urandom), idx, pick_level());
				if (idx < TABLE_ENTRIES_DEF)
					counted++;
			end else begin
				send_item(CMD_MAP, pick_level(), INDEX_W'($urandom), DATA_W'($urandom));
				counted++;
			end
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
